// ----- rtl/btx_pkg.sv -----
package btx_pkg;

  localparam int MAX_WIDTH_DEF  = 128;
  localparam int MAX_HEIGHT_DEF = 128;
  localparam int CHANNELS_DEF   = 3;

  // front queue and result queue depths
  localparam int FQ_DEPTH = 8;
  localparam int OQ_DEPTH = 4;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [1:0] WRAP_REPEAT = 2'd0;
  localparam logic [1:0] WRAP_CLAMP  = 2'd1;
  localparam logic [1:0] WRAP_BLACK  = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_WRAP   = 2'd2;
  localparam logic [1:0] REG_SRGB   = 2'd3;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef struct packed {
    logic [7:0] w;
    logic [7:0] h;
    logic [1:0] wrap;
    logic       srgb;
  } cfg_t;

  typedef struct packed {
    logic              cmd;
    logic [6:0]        x;
    logic [6:0]        y;
    logic [1:0]        ch;
    logic [7:0]        tbyte;
    logic signed [12:0] si;
    logic signed [12:0] ti;
    logic [15:0]       ds;
    logic [15:0]       dt;
    logic [7:0]        ms;
    logic [7:0]        mt;
  } req_t;

  typedef struct packed {
    req_t        req;
    logic [12:0] abs_s;
    logic [12:0] abs_t;
  } fs_t;

  typedef struct packed {
    logic [7:0] c;
    logic       ok;
  } rm_t;

  typedef logic [255:0][16:0] lut_t;

  localparam logic [33:0] SRGB_RAW [256] = '{
    34'd0, 34'd3035270, 34'd6070540, 34'd9105810, 34'd12141080,
    34'd15176350, 34'd18211619, 34'd21246888, 34'd24282159, 34'd27317430,
    34'd30352699, 34'd33465356, 34'd36765069, 34'd40247170, 34'd43914421,
    34'd47769533, 34'd51815170, 34'd56053917, 34'd60488326, 34'd65120910,
    34'd69954102, 34'd74990317, 34'd80231922, 34'd85681248, 34'd91340570,
    34'd97212177, 34'd103298230, 34'd109600937, 34'd116122449, 34'd122864870,
    34'd129830306, 34'd137020806, 34'd144438436, 34'd152085144, 34'd159962922,
    34'd168073755, 34'd176419523, 34'd185002182, 34'd193823613, 34'd202885624,
    34'd212190095, 34'd221738834, 34'd231533647, 34'd241576303, 34'd251868572,
    34'd262412224, 34'd273208916, 34'd284260381, 34'd295568332, 34'd307134409,
    34'd318960287, 34'd331047624, 34'd343398079, 34'd356013142, 34'd368894450,
    34'd382043645, 34'd395462364, 34'd409151986, 34'd423114114, 34'd437350273,
    34'd451862030, 34'd466650836, 34'd481718220, 34'd497065634, 34'd512694679,
    34'd528606549, 34'd544802807, 34'd561284944, 34'd578054339, 34'd595112406,
    34'd612460710, 34'd630100295, 34'd648032799, 34'd666259527, 34'd684781820,
    34'd703601092, 34'd722718611, 34'd742135793, 34'd761853904, 34'd781874284,
    34'd802198276, 34'd822827145, 34'd843762159, 34'd865004659, 34'd886556059,
    34'd908417329, 34'd930589810, 34'd953074843, 34'd975873619, 34'd998987406,
    34'd1022417471, 34'd1046164930, 34'd1070231125, 34'd1094617173, 34'd1119324341,
    34'd1144353822, 34'd1169706732, 34'd1195384338, 34'd1221387982, 34'd1247718409,
    34'd1274376959, 34'd1301364899, 34'd1328683347, 34'd1356333494, 34'd1384316236,
    34'd1412633061, 34'd1441284865, 34'd1470272839, 34'd1499598026, 34'd1529261619,
    34'd1559264660, 34'd1589608639, 34'd1620294005, 34'd1651322246, 34'd1682693958,
    34'd1714410931, 34'd1746473908, 34'd1778884083, 34'd1811642349, 34'd1844749898,
    34'd1878207624, 34'd1912016720, 34'd1946178079, 34'd1980693042, 34'd2015562356,
    34'd2050787061, 34'd2086368501, 34'd2122307271, 34'd2158605307, 34'd2195262313,
    34'd2232279778, 34'd2269658893, 34'd2307400703, 34'd2345506549, 34'd2383976579,
    34'd2422811985, 34'd2462013960, 34'd2501583695, 34'd2541521788, 34'd2581829131,
    34'd2622507215, 34'd2663556635, 34'd2704978585, 34'd2746773660, 34'd2788943350,
    34'd2831487954, 34'd2874408960, 34'd2917706966, 34'd2961383164, 34'd3005438447,
    34'd3049873710, 34'd3094689548, 34'd3139887452, 34'd3185468316, 34'd3231432438,
    34'd3277781308, 34'd3324515820, 34'd3371636569, 34'd3419144452, 34'd3467040956,
    34'd3515326977, 34'd3564002514, 34'd3613068759, 34'd3662526906, 34'd3712377846,
    34'd3762622178, 34'd3813261092, 34'd3864295185, 34'd3915725648, 34'd3967553079,
    34'd4019778669, 34'd4072403014, 34'd4125427008, 34'd4178851545, 34'd4232677519,
    34'd4286905527, 34'd4341537058, 34'd4396572411, 34'd4452012479, 34'd4507858455,
    34'd4564110637, 34'd4620770514, 34'd4677838385, 34'd4735315442, 34'd4793202281,
    34'd4851499796, 34'd4910208881, 34'd4969330430, 34'd5028865933, 34'd5088814497,
    34'd5149177909, 34'd5209956765, 34'd5271152258, 34'd5332764983, 34'd5394796133,
    34'd5457245708, 34'd5520114899, 34'd5583404899, 34'd5647116303, 34'd5711249113,
    34'd5775805116, 34'd5840784907, 34'd5906189084, 34'd5972018838, 34'd6038274169,
    34'd6104956269, 34'd6172066331, 34'd6239604354, 34'd6307572126, 34'd6375969648,
    34'd6444797516, 34'd6514056921, 34'd6583748460, 34'd6653873324, 34'd6724432111,
    34'd6795425415, 34'd6866854429, 34'd6938719153, 34'd7011020184, 34'd7083759308,
    34'd7156936526, 34'd7230552435, 34'd7304608822, 34'd7379105687, 34'd7454043627,
    34'd7529423237, 34'd7605246305, 34'd7681512833, 34'd7758223414, 34'd7835379243,
    34'd7912980318, 34'd7991028428, 34'd8069523573, 34'd8148466945, 34'd8227858543,
    34'd8307699561, 34'd8387991190, 34'd8468732834, 34'd8549926877, 34'd8631572723,
    34'd8713672161, 34'd8796223402, 34'd8879231811, 34'd8962693810, 34'd9046613574,
    34'd9130986929, 34'd9215820432, 34'd9301108718, 34'd9386858940, 34'd9473065734,
    34'd9559735060, 34'd9646862745, 34'd9734454751, 34'd9822505713, 34'd9911022186,
    34'd10000000000};

  function automatic lut_t build_srgb();
    lut_t   t;
    logic [63:0] d;
    for (int i = 0; i < 256; i++) begin
      d = (64'(SRGB_RAW[i]) * 64'd65536 + 64'd5000000000) / 64'd10000000000;
      t[i] = d[16:0];
    end
    return t;
  endfunction

  function automatic lut_t build_lin();
    lut_t   t;
    logic [31:0] d;
    for (int i = 0; i < 256; i++) begin
      d = (32'(i) * 32'd65536 + 32'd127) / 32'd255;
      t[i] = d[16:0];
    end
    return t;
  endfunction

  localparam lut_t SRGB_LUT = build_srgb();
  localparam lut_t LIN_LUT  = build_lin();

  // four restoring remainder steps, one dividend bit each
  function automatic logic [7:0] mod_step4(logic [7:0] r, logic [3:0] b, logic [7:0] n);
    logic [8:0] t;
    t = {1'b0, r};
    for (int i = 3; i >= 0; i--) begin
      t = {t[7:0], b[i]};
      if (t >= {1'b0, n}) t = t - {1'b0, n};
    end
    return t[7:0];
  endfunction

endpackage

// ----- rtl/btx_fifo.sv -----
module btx_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [W-1:0]               din,
  input  logic                       pop,
  output logic [W-1:0]               dout,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign dout  = mem_r[rp_r];
  assign count = cnt_r;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == PW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

endmodule

// ----- rtl/btx_front.sv -----
module btx_front (
  input  logic                clk,
  input  logic                rst_n,
  input  btx_pkg::cfg_t       cfg,
  input  logic                acc,
  input  logic                cmd,
  input  logic [63:0]         tdata,
  output logic                push,
  output btx_pkg::req_t       push_req,
  output logic [2:0]          inflight
);

  localparam int NST = 5;

  btx_pkg::fs_t st_r [NST];
  btx_pkg::fs_t st_nxt [NST];
  logic [NST-1:0] vld_r;

  logic signed [19:0] u_s, v_s;
  logic signed [28:0] s_full, t_full;
  logic [15:0] abs16_s, abs16_t;

  always_comb begin
    u_s    = $signed(tdata[43:24]);
    v_s    = $signed(tdata[63:44]);
    s_full = 29'(u_s) * 29'($signed({1'b0, cfg.w})) - 29'sd32768;
    t_full = 29'(v_s) * 29'($signed({1'b0, cfg.h})) - 29'sd32768;

    st_nxt[0]           = '0;
    st_nxt[0].req.cmd   = cmd;
    st_nxt[0].req.x     = tdata[6:0];
    st_nxt[0].req.y     = tdata[13:7];
    st_nxt[0].req.ch    = tdata[15:14];
    st_nxt[0].req.tbyte = tdata[23:16];
    st_nxt[0].req.si    = s_full[28:16];
    st_nxt[0].req.ti    = t_full[28:16];
    st_nxt[0].req.ds    = s_full[15:0];
    st_nxt[0].req.dt    = t_full[15:0];

    abs16_s = '0;
    abs16_t = '0;
    for (int k = 0; k < NST-1; k++) begin
      st_nxt[k+1] = st_r[k];
      if (k == 0) begin
        st_nxt[1].abs_s = st_r[0].req.si[12] ? 13'(-st_r[0].req.si) : 13'(st_r[0].req.si);
        st_nxt[1].abs_t = st_r[0].req.ti[12] ? 13'(-st_r[0].req.ti) : 13'(st_r[0].req.ti);
      end
      abs16_s = {3'b0, st_nxt[k+1].abs_s};
      abs16_t = {3'b0, st_nxt[k+1].abs_t};
      st_nxt[k+1].req.ms = btx_pkg::mod_step4(st_nxt[k+1].req.ms, abs16_s[15-4*k -: 4], cfg.w);
      st_nxt[k+1].req.mt = btx_pkg::mod_step4(st_nxt[k+1].req.mt, abs16_t[15-4*k -: 4], cfg.h);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NST; k++) st_r[k] <= st_nxt[k];
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[NST-2:0], acc};
  end

  // turn the remainders of |s| and |t| into nonnegative modulos
  always_comb begin
    push_req = st_r[NST-1].req;
    if (st_r[NST-1].req.si[12] && st_r[NST-1].req.ms != '0)
      push_req.ms = cfg.w - st_r[NST-1].req.ms;
    if (st_r[NST-1].req.ti[12] && st_r[NST-1].req.mt != '0)
      push_req.mt = cfg.h - st_r[NST-1].req.mt;
  end

  assign push     = vld_r[NST-1];
  assign inflight = 3'($countones(vld_r));

endmodule

// ----- rtl/btx_back.sv -----
module btx_back #(
  parameter int MAX_WIDTH  = btx_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = btx_pkg::MAX_HEIGHT_DEF,
  parameter int CHANNELS   = btx_pkg::CHANNELS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  btx_pkg::cfg_t cfg,
  input  logic          hv,
  input  btx_pkg::req_t head,
  output logic          pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [16:0]   out_value
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * CHANNELS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCW   = $clog2(btx_pkg::OQ_DEPTH + 1);

  function automatic btx_pkg::rm_t remap(logic signed [12:0] si, logic [7:0] ms, logic dx,
                                         logic [7:0] n, logic [1:0] mode);
    logic signed [13:0] v;
    logic [8:0]         inc;
    btx_pkg::rm_t       r;
    v    = $signed({si[12], si}) + $signed({13'd0, dx});
    inc  = {1'b0, ms} + 9'd1;
    r.ok = 1'b1;
    r.c  = v[7:0];
    case (mode)
      btx_pkg::WRAP_REPEAT: begin
        if (dx) r.c = (inc == {1'b0, n}) ? 8'd0 : inc[7:0];
        else    r.c = ms;
      end
      btx_pkg::WRAP_CLAMP: begin
        if (v < 0)                           r.c = 8'd0;
        else if (v >= $signed({6'd0, n}))    r.c = n - 8'd1;
      end
      default: begin
        r.ok = (v >= 0) && (v < $signed({6'd0, n}));
      end
    endcase
    return r;
  endfunction

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata_r;
  logic [1:0]    phase_r;
  logic [OCW-1:0] pend_r, oq_cnt;

  logic          is_load, load_ok, can_start, issue, we, badch;
  btx_pkg::rm_t  rx, ry;
  logic [AW-1:0] waddr, raddr;

  always_comb begin
    is_load   = head.cmd == btx_pkg::CMD_LOAD;
    badch     = head.ch >= 2'(CHANNELS);
    load_ok   = (13'(head.x) < 13'(MAX_WIDTH)) && (13'(head.y) < 13'(MAX_HEIGHT)) && !badch;
    can_start = ({1'b0, oq_cnt} + {1'b0, pend_r}) < (OCW+1)'(btx_pkg::OQ_DEPTH);
    issue     = hv && !is_load && (phase_r != 2'd0 || can_start);
    we        = hv && is_load && load_ok;
    pop       = hv && (is_load || (issue && phase_r == 2'd3));
    rx        = remap(head.si, head.ms, phase_r[1], cfg.w, cfg.wrap);
    ry        = remap(head.ti, head.mt, phase_r[0], cfg.h, cfg.wrap);
    waddr     = AW'((AW'(head.y) * AW'(MAX_WIDTH) + AW'(head.x)) * AW'(CHANNELS) + AW'(head.ch));
    raddr     = AW'((AW'(ry.c) * AW'(MAX_WIDTH) + AW'(rx.c)) * AW'(CHANNELS) + AW'(head.ch));
  end

  // single port: a load writes, a sample reads one neighbour
  always_ff @(posedge clk) begin
    if (we)         mem[waddr] <= head.tbyte;
    else if (issue) rdata_r    <= mem[raddr];
  end

  logic        s1_vld_r, s1_black_r;
  logic [1:0]  s1_p_r;
  logic [16:0] s1_wx_r, s1_wy_r;
  logic [16:0] val;
  logic [33:0] m;

  logic        s2_vld_r;
  logic [1:0]  s2_p_r;
  logic [16:0] s2_wx_r;
  logic [33:0] s2_m_r;
  logic [32:0] col_r;

  logic        s3_vld_r, s3_last_r;
  logic [16:0] s3_wx_r;
  logic [32:0] s3_col_r;

  logic        s4_vld_r, s4_last_r;
  logic [33:0] lo4_r;
  logic [32:0] hi4_r;
  logic [49:0] acc_r, part, total;
  logic        res_push;

  always_comb begin
    if (s1_black_r)   val = '0;
    else if (cfg.srgb) val = btx_pkg::SRGB_LUT[rdata_r];
    else              val = btx_pkg::LIN_LUT[rdata_r];
    m        = s1_wy_r * val;
    part     = 50'(lo4_r) + (50'(hi4_r) << 17);
    total    = acc_r + part + 50'h80000000;
    res_push = s4_vld_r && s4_last_r;
  end

  always_ff @(posedge clk) begin
    s1_p_r     <= phase_r;
    s1_black_r <= badch || !rx.ok || !ry.ok;
    s1_wx_r    <= phase_r[1] ? {1'b0, head.ds} : btx_pkg::ONE_Q16 - {1'b0, head.ds};
    s1_wy_r    <= phase_r[0] ? {1'b0, head.dt} : btx_pkg::ONE_Q16 - {1'b0, head.dt};

    s2_p_r  <= s1_p_r;
    s2_wx_r <= s1_wx_r;
    s2_m_r  <= m;

    if (s2_vld_r && !s2_p_r[0]) col_r <= s2_m_r[32:0];
    s3_col_r  <= col_r + s2_m_r[32:0];
    s3_wx_r   <= s2_wx_r;
    s3_last_r <= s2_p_r[1];

    lo4_r     <= s3_wx_r * s3_col_r[16:0];
    hi4_r     <= s3_wx_r * s3_col_r[32:17];
    s4_last_r <= s3_last_r;

    if (s4_vld_r && !s4_last_r) acc_r <= part;

    if (!rst_n) begin
      phase_r  <= '0;
      pend_r   <= '0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      if (issue) phase_r <= phase_r + 2'd1;
      pend_r   <= pend_r + OCW'(issue && phase_r == 2'd0) - OCW'(res_push);
      s1_vld_r <= issue;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r && s2_p_r[0];
      s4_vld_r <= s3_vld_r;
    end
  end

  btx_fifo #(.W(17), .DEPTH(btx_pkg::OQ_DEPTH)) u_oq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (total[48:32]),
    .pop   (out_tvalid && out_tready),
    .dout  (out_value),
    .count (oq_cnt)
  );

  assign out_tvalid = oq_cnt != '0;

endmodule

// ----- rtl/bilinear_texel_sampler.sv -----
// Bilinear texel sampler over an on-chip 8-bit texel image.
// Input stream (in_*): in_tuser = 0 loads one texel byte, 1 samples at (u, v).
// Result stream (out_*): one filtered Q1.16 value per sample request; loads
// produce nothing. Results leave in request order.
// Configuration port: cfg_we writes register cfg_addr (0 width, 1 height,
// 2 wrap mode, 3 sRGB decode) at the clock edge; write only while idle.
// Throughput is set by the single texel memory port, which reads a sample's
// four neighbours one per cycle; a load is a single write.
// A request passes the 5-stage front (coordinate product and wrap
// remainder), the front queue, the read, decode/weight and blend.
// The front queue lets new requests enter while the back end works, and a
// 4-entry result queue keeps the back end running while the receiver stalls;
// in_tready drops once the front queue has no room beyond requests in flight.
// Reset (rst_n low, synchronous) empties all queues and sets 128x128, clamp,
// linear decode. The texel memory is not cleared: sample only loaded texels.
module bilinear_texel_sampler #(
  parameter int MAX_WIDTH  = btx_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = btx_pkg::MAX_HEIGHT_DEF,
  parameter int CHANNELS   = btx_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // texel_x, texel_y, channel, texel_byte, coord_u, coord_v
  input  logic [63:0] in_tdata,
  // cmd
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // sample_value, zero fill
  output logic [23:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  localparam int FCW = $clog2(btx_pkg::FQ_DEPTH + 1);
  localparam int RW  = $bits(btx_pkg::req_t);

  logic [7:0] width_r, height_r;
  logic [1:0] wrap_r;
  logic       srgb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 8'd128;
      height_r <= 8'd128;
      wrap_r   <= btx_pkg::WRAP_CLAMP;
      srgb_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        btx_pkg::REG_WIDTH:  width_r  <= cfg_wdata;
        btx_pkg::REG_HEIGHT: height_r <= cfg_wdata;
        btx_pkg::REG_WRAP:   wrap_r   <= cfg_wdata[1:0];
        btx_pkg::REG_SRGB:   srgb_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  btx_pkg::cfg_t cfg;

  always_comb begin
    cfg.wrap = wrap_r;
    cfg.srgb = srgb_r;
    if (width_r == 8'd0)                      cfg.w = 8'd1;
    else if ({5'd0, width_r} > 13'(MAX_WIDTH)) cfg.w = 8'(MAX_WIDTH);
    else                                      cfg.w = width_r;
    if (height_r == 8'd0)                       cfg.h = 8'd1;
    else if ({5'd0, height_r} > 13'(MAX_HEIGHT)) cfg.h = 8'(MAX_HEIGHT);
    else                                        cfg.h = height_r;
  end

  logic           acc, fpush, fpop;
  logic [2:0]     inflight;
  logic [FCW-1:0] fq_cnt;
  btx_pkg::req_t  freq, head;
  logic [RW-1:0]  head_bits;
  logic [16:0]    out_value;

  // hold off requests unless the front queue has room for everything in flight
  assign in_tready = ({1'b0, fq_cnt} + (FCW+1)'(inflight)) < (FCW+1)'(btx_pkg::FQ_DEPTH);
  assign acc       = in_tvalid && in_tready;

  btx_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .acc      (acc),
    .cmd      (in_tuser),
    .tdata    (in_tdata),
    .push     (fpush),
    .push_req (freq),
    .inflight (inflight)
  );

  btx_fifo #(.W(RW), .DEPTH(btx_pkg::FQ_DEPTH)) u_fq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fpush),
    .din   (freq),
    .pop   (fpop),
    .dout  (head_bits),
    .count (fq_cnt)
  );

  assign head = btx_pkg::req_t'(head_bits);

  btx_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CHANNELS   (CHANNELS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .hv         (fq_cnt != '0),
    .head       (head),
    .pop        (fpop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_value  (out_value)
  );

  assign out_tdata = {7'd0, out_value};

endmodule

// ----- rtl/btx_checker.sv -----
module btx_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present after reset");

  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("not ready after reset");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[23:17] == 7'd0) && (out_tdata[16] == 1'b0 || out_tdata[15:0] == 16'd0))
    else $error("sample value above one");

endmodule

bind bilinear_texel_sampler btx_checker u_btx_checker (.*);

// ----- tb/tb_bilinear_texel_sampler.sv -----
module tb_bilinear_texel_sampler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IMG_W = 128;
  localparam int IMG_H = 128;
  localparam int NCH = 3;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // texel_x, texel_y, channel, texel_byte, coord_u, coord_v
  logic [63:0] in_tdata;
  // cmd
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  // sample_value, zero fill
  logic [23:0] out_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [7:0]  cfg_wdata;

  bilinear_texel_sampler DUT (.*);

  typedef struct packed {
    logic              cmd;
    logic [6:0]        x;
    logic [6:0]        y;
    logic [1:0]        ch;
    logic [7:0]        tbyte;
    logic signed [19:0] u;
    logic signed [19:0] v;
  } texreq_t;

  // model state
  logic [7:0]  texels [IMG_W*IMG_H*NCH];
  bit          loaded [IMG_W*IMG_H*NCH];
  logic [7:0]  img_w, img_h;
  logic [1:0]  wrap;
  logic        srgb;
  logic [16:0] pending_samples [$];

  int errors;
  int send_idle_pct, recv_stall_pct;
  bit recv_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("bilinear_texel_sampler regression: fail");
    $finish;
  end

  function automatic int eff_size(logic [7:0] r, int maxv);
    int n;
    n = r;
    if (n < 1) n = 1;
    if (n > maxv) n = maxv;
    return n;
  endfunction

  // remap one coordinate; returns 0 when the neighbor reads black
  function automatic bit remap_coord(ref longint p, input longint n);
    if (wrap == btx_pkg::WRAP_REPEAT) begin
      p = p % n;
      if (p < 0) p += n;
    end else if (wrap == btx_pkg::WRAP_CLAMP) begin
      if (p < 0) p = 0;
      if (p > n - 1) p = n - 1;
    end else begin
      return p >= 0 && p < n;
    end
    return 1'b1;
  endfunction

  function automatic longint unsigned texel_level(longint x, longint y, longint w,
                                                  longint h, int c);
    logic [7:0] b;
    if (!remap_coord(x, w) || !remap_coord(y, h)) return 0;
    b = texels[(y*IMG_W + x)*NCH + c];
    if (srgb)
      return (longint'(btx_pkg::SRGB_RAW[b]) * 65536 + 64'd5000000000) / 64'd10000000000;
    return (longint'(b) * 65536 + 127) / 255;
  endfunction

  function automatic logic [16:0] filter_value(texreq_t r);
    longint w, h, s, t, si, ti;
    longint unsigned ds, dt, acc;
    if (r.ch >= NCH) return '0;
    w = eff_size(img_w, IMG_W);
    h = eff_size(img_h, IMG_H);
    s = longint'(r.u) * w - 32768;
    t = longint'(r.v) * h - 32768;
    si = ((s + (64'sd1 << 40)) >>> 16) - (64'sd1 << 24);
    ti = ((t + (64'sd1 << 40)) >>> 16) - (64'sd1 << 24);
    ds = (s + (64'sd1 << 40)) & 64'hFFFF;
    dt = (t + (64'sd1 << 40)) & 64'hFFFF;
    acc = (65536 - ds) * (65536 - dt) * texel_level(si, ti, w, h, r.ch)
        + (65536 - ds) * dt * texel_level(si, ti + 1, w, h, r.ch)
        + ds * (65536 - dt) * texel_level(si + 1, ti, w, h, r.ch)
        + ds * dt * texel_level(si + 1, ti + 1, w, h, r.ch);
    return 17'((acc + 64'h80000000) >> 32);
  endfunction

  // true when all four neighbors of a sample were loaded (or read black)
  function automatic bit reads_loaded(texreq_t r);
    longint w, h, s, t, si, ti, x, y;
    if (r.ch >= NCH) return 1'b1;
    w = eff_size(img_w, IMG_W);
    h = eff_size(img_h, IMG_H);
    s = longint'(r.u) * w - 32768;
    t = longint'(r.v) * h - 32768;
    si = ((s + (64'sd1 << 40)) >>> 16) - (64'sd1 << 24);
    ti = ((t + (64'sd1 << 40)) >>> 16) - (64'sd1 << 24);
    for (int k = 0; k < 4; k++) begin
      x = si + k[0];
      y = ti + k[1];
      if (remap_coord(x, w) && remap_coord(y, h))
        if (!loaded[(y*IMG_W + x)*NCH + r.ch]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic send_request(texreq_t r);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.cmd;
    in_tdata  <= {r.v, r.u, r.tbyte, r.ch, r.y, r.x};
    do @(posedge clk); while (!in_tready);
    if (r.cmd == btx_pkg::CMD_LOAD) begin
      if (r.ch < NCH) begin
        texels[(r.y*IMG_W + r.x)*NCH + r.ch] = r.tbyte;
        loaded[(r.y*IMG_W + r.x)*NCH + r.ch] = 1'b1;
      end
    end else begin
      pending_samples = {pending_samples, filter_value(r)};
    end
  endtask

  task automatic load_texel(int x, int y, int c, int b);
    texreq_t r;
    r = '0;
    r.cmd = btx_pkg::CMD_LOAD; r.x = 7'(x); r.y = 7'(y); r.ch = 2'(c); r.tbyte = 8'(b);
    send_request(r);
  endtask

  // sample only where the neighbors hold known bytes
  task automatic sample_at(logic signed [19:0] u, logic signed [19:0] v, int c);
    texreq_t r;
    r = '0;
    r.cmd = btx_pkg::CMD_SAMPLE; r.ch = 2'(c); r.u = u; r.v = v;
    r.x = 7'($urandom); r.y = 7'($urandom); r.tbyte = 8'($urandom);
    if (reads_loaded(r)) send_request(r);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] a, logic [7:0] d);
    cfg_we <= 1'b1; cfg_addr <= a; cfg_wdata <= d;
    @(posedge clk);
    case (a)
      btx_pkg::REG_WIDTH:  img_w = d;
      btx_pkg::REG_HEIGHT: img_h = d;
      btx_pkg::REG_WRAP:   wrap = d[1:0];
      default:             srgb = d[0];
    endcase
  endtask

  task automatic set_image(int w, int h, int m, int s);
    drain();
    write_reg(btx_pkg::REG_WIDTH, 8'(w));
    write_reg(btx_pkg::REG_HEIGHT, 8'(h));
    write_reg(btx_pkg::REG_WRAP, 8'(m));
    write_reg(btx_pkg::REG_SRGB, 8'(s));
    cfg_we <= 1'b0;
  endtask

  // fill every channel of the region actually reachable with the given size
  task automatic fill_image(int w, int h);
    int ww, hh;
    ww = eff_size(8'(w), IMG_W); hh = eff_size(8'(h), IMG_H);
    for (int y = 0; y < hh; y++)
      for (int x = 0; x < ww; x++)
        for (int c = 0; c < NCH; c++) load_texel(x, y, c, $urandom_range(255));
  endtask

  function automatic logic signed [19:0] rand_coord();
    case ($urandom_range(3))
      0: return 20'($urandom);
      1: return 20'($urandom_range(65536));
      2: return 20'(65536 * ($signed($urandom_range(6)) - 3) + int'($urandom_range(65535)));
      default: return ($urandom_range(1) != 0) ? 20'sh7FFFF : 20'sh80000;
    endcase
  endfunction

  task automatic test_directed();
    logic signed [19:0] edges [6];
    edges = '{20'sh80000, 20'sh7FFFF, 20'sd0, 20'sd65536, 20'sd32768, -20'sd1};
    set_image(2, 2, btx_pkg::WRAP_CLAMP, 0);
    load_texel(0, 0, 0, 0);
    load_texel(1, 0, 0, 255);
    load_texel(0, 1, 0, 128);
    load_texel(1, 1, 0, 1);
    load_texel(127, 127, 2, 200);
    // ignored: channel three
    load_texel(0, 0, 3, 99);
    foreach (edges[i]) sample_at(edges[i], edges[5-i], 0);
    sample_at(20'sd1000, 20'sd2000, 3);
    for (int m = 0; m < 4; m++) begin
      set_image(2, 2, m, m & 1);
      sample_at(20'sd70000, -20'sd5000, 0);
      sample_at(-20'sd100000, 20'sd40000, 0);
    end
    // zero size acts as one texel
    set_image(0, 0, btx_pkg::WRAP_REPEAT, 1);
    sample_at(20'sd12345, -20'sd54321, 0);
    set_image(255, 200, btx_pkg::WRAP_CLAMP, 0);
    sample_at(20'sh7FFFF, 20'sh7FFFF, 2);
  endtask

  task automatic test_random(int n, int sz_max);
    int w, h;
    w = $urandom_range(sz_max, 1); h = $urandom_range(sz_max, 1);
    set_image(w, h, $urandom_range(3), $urandom_range(1));
    fill_image(w, h);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(15) == 0)
        load_texel($urandom_range(w-1), $urandom_range(h-1), $urandom_range(3),
                   $urandom_range(255));
      else
        sample_at(rand_coord(), rand_coord(), $urandom_range(9) == 0 ? 3 : $urandom_range(2));
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        recv_hold = 1'b1;
        repeat (400) @(posedge clk);
        recv_hold = 1'b0;
      end
      for (int i = 0; i < 40; i++) sample_at(rand_coord(), rand_coord(), $urandom_range(2));
    join
    drain();
  endtask

  initial begin
    errors = 0;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tuser = 1'b0;
    out_tready = 1'b0; cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
    send_idle_pct = 0; recv_stall_pct = 0; recv_hold = 1'b0;
    img_w = 128; img_h = 128; wrap = btx_pkg::WRAP_CLAMP; srgb = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = (p == 1 || p == 3) ? (p == 3 ? 8 : 63) : 0;
      recv_stall_pct = (p >= 2) ? (p == 3 ? 8 : 63) : 0;
      test_random(200, 8);
    end
    send_idle_pct = 0; recv_stall_pct = 0;
    test_random(150, 12);
    test_random(150, 1);
    test_backpressure();
    drain();
    if (errors == 0) $display("bilinear_texel_sampler regression: pass");
    else $display("bilinear_texel_sampler regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= !recv_hold && $urandom_range(99) >= recv_stall_pct;
  end

  always @(posedge clk) begin
    logic [16:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_samples.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %0d", out_tdata[16:0]);
      end else begin
        want = pending_samples.pop_front();
        if (out_tdata[16:0] !== want) begin
          errors++;
          if (errors <= 10)
            $display("sample_value mismatch: expected %0d, got %0d", want, out_tdata[16:0]);
        end
      end
    end
  end

endmodule
